>>> sv/rdte_pkg.sv
// rdte_pkg: shared types and constants for the rgb555 run/delta token encoder
// used by rdte_front, rdte_fifo, rdte_back and the top level; no dependencies
package rdte_pkg;

    localparam int CHAN_W = 5;
    localparam int RUN_W  = 6;

    localparam logic [RUN_W-1:0]  RUN_MAX   = 6'd32;
    localparam logic [CHAN_W-1:0] ZERO_CHAN = 5'd0;

    typedef enum logic [1:0] {
        KIND_REPEAT  = 2'd0,
        KIND_RAW     = 2'd1,
        KIND_ASCEND  = 2'd2,
        KIND_DESCEND = 2'd3
    } t_kind;

    // one queued command: an optional run flush followed by an optional color token
    typedef struct packed {
        logic              rep_valid;
        logic [CHAN_W-1:0] rep_run;
        logic              main_valid;
        t_kind             kind;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              eoi;
    } t_cmd;

endpackage

>>> sv/rle_delta_rgb555_token_encoder.sv
// rle_delta_rgb555_token_encoder: top level, front classifier, command queue, token back end
// depends on rdte_pkg, rdte_front, rdte_fifo, rdte_back
//
// Input channel: i_in_valid / o_in_stall carry one rgb555 pixel and a final-pixel flag
// per transaction. Output channel: o_out_valid / i_out_stall carry one token per
// transaction (repeat, raw, ascend or descend) with last-of-item and end-of-image marks.
// A pixel makes zero, one or two tokens; a pixel that only extends a run makes none.
// The front accepts one pixel per cycle whenever the command queue has room and queues
// at most one command per pixel; the back turns each command into its tokens, one token
// per cycle into the output register while the receiver does not stall.
// A pixel's first token passes through the command queue and then the output register
// before it shows on o_out_valid. Throughput is one pixel per cycle while pixels make at
// most one token each and the receiver does not stall; a run flush adds a token, and the
// single output register drains one token per cycle.
// Reset (synchronous, active low) empties the queue and output register and returns the
// last color to black with no pending run; a final pixel resets the color and run alike.
// While the receiver stalls, the output token holds; the queue absorbs QUEUE_DEPTH
// commands and then o_in_stall rises until the back end drains.
module rle_delta_rgb555_token_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pixel,
    input  logic        i_final_pixel,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_token_kind,
    output logic [4:0]  o_run_minus_one,
    output logic [4:0]  o_blue_value,
    output logic [4:0]  o_green_value,
    output logic [4:0]  o_red_value,
    output logic        o_last_of_item,
    output logic        o_end_of_image
);

    rdte_pkg::t_cmd w_push_cmd, w_head_cmd;
    logic           w_push, w_pop, w_q_full, w_head_valid;

    rdte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_pixel       (i_pixel),
        .i_final_pixel (i_final_pixel),
        .i_q_full      (w_q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    rdte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_full  (w_q_full),
        .o_data  (w_head_cmd)
    );

    rdte_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head_cmd),
        .i_out_stall     (i_out_stall),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .o_token_kind    (o_token_kind),
        .o_run_minus_one (o_run_minus_one),
        .o_blue_value    (o_blue_value),
        .o_green_value   (o_green_value),
        .o_red_value     (o_red_value),
        .o_last_of_item  (o_last_of_item),
        .o_end_of_image  (o_end_of_image)
    );

endmodule

>>> sv/rdte_front.sv
// rdte_front: accepts pixels, tracks last color and run count, builds commands
// depends on rdte_pkg
module rdte_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [15:0]        i_pixel,
    input  logic               i_final_pixel,
    input  logic               i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output rdte_pkg::t_cmd     o_cmd
);

    logic [rdte_pkg::CHAN_W-1:0] r_prev_b, r_prev_g, r_prev_r;
    logic [rdte_pkg::CHAN_W-1:0] n_prev_b, n_prev_g, n_prev_r;
    logic [rdte_pkg::RUN_W-1:0]  r_run_count, n_run_count;

    logic [rdte_pkg::CHAN_W-1:0] w_b, w_g, w_r;
    logic [rdte_pkg::CHAN_W-1:0] w_ub, w_ug, w_ur, w_db, w_dg, w_dr;
    logic [rdte_pkg::RUN_W-1:0]  w_run_dec;
    logic                        w_accept, w_extend, w_asc, w_desc;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    always_comb begin
        w_b = i_pixel[4:0];
        w_g = i_pixel[10:6];
        w_r = i_pixel[15:11];
        w_ub = w_b - r_prev_b;
        w_ug = w_g - r_prev_g;
        w_ur = w_r - r_prev_r;
        w_db = r_prev_b - w_b;
        w_dg = r_prev_g - w_g;
        w_dr = r_prev_r - w_r;
        w_asc  = (w_ub[4:3] == 2'b00) && (w_ug[4:3] == 2'b00) && (w_ur[4:3] == 2'b00);
        w_desc = (w_db[4:3] == 2'b00) && (w_dg[4:3] == 2'b00) && (w_dr[4:3] == 2'b00);
        w_extend = (w_b == r_prev_b) && (w_g == r_prev_g) && (w_r == r_prev_r)
                   && (r_run_count < rdte_pkg::RUN_MAX);
        w_run_dec = r_run_count - 6'd1;

        o_cmd.eoi = i_final_pixel;
        if (w_extend) begin
            o_cmd.rep_valid  = 1'b1;
            o_cmd.rep_run    = r_run_count[rdte_pkg::CHAN_W-1:0];
            o_cmd.main_valid = 1'b0;
            o_cmd.kind       = rdte_pkg::KIND_REPEAT;
            o_cmd.blue       = rdte_pkg::ZERO_CHAN;
            o_cmd.green      = rdte_pkg::ZERO_CHAN;
            o_cmd.red        = rdte_pkg::ZERO_CHAN;
        end else begin
            o_cmd.rep_valid  = (r_run_count != '0);
            o_cmd.rep_run    = w_run_dec[rdte_pkg::CHAN_W-1:0];
            o_cmd.main_valid = 1'b1;
            priority if (w_asc) begin
                o_cmd.kind  = rdte_pkg::KIND_ASCEND;
                o_cmd.blue  = w_ub;
                o_cmd.green = w_ug;
                o_cmd.red   = w_ur;
            end else if (w_desc) begin
                o_cmd.kind  = rdte_pkg::KIND_DESCEND;
                o_cmd.blue  = w_db;
                o_cmd.green = w_dg;
                o_cmd.red   = w_dr;
            end else begin
                o_cmd.kind  = rdte_pkg::KIND_RAW;
                o_cmd.blue  = w_b;
                o_cmd.green = w_g;
                o_cmd.red   = w_r;
            end
        end
        o_push = w_accept && (!w_extend || i_final_pixel);

        n_prev_b    = r_prev_b;
        n_prev_g    = r_prev_g;
        n_prev_r    = r_prev_r;
        n_run_count = r_run_count;
        if (w_accept) begin
            priority if (i_final_pixel) begin
                n_prev_b    = '0;
                n_prev_g    = '0;
                n_prev_r    = '0;
                n_run_count = '0;
            end else if (w_extend) begin
                n_run_count = r_run_count + 6'd1;
            end else begin
                n_prev_b    = w_b;
                n_prev_g    = w_g;
                n_prev_r    = w_r;
                n_run_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_b    <= '0;
            r_prev_g    <= '0;
            r_prev_r    <= '0;
            r_run_count <= '0;
        end else begin
            r_prev_b    <= n_prev_b;
            r_prev_g    <= n_prev_g;
            r_prev_r    <= n_prev_r;
            r_run_count <= n_run_count;
        end
    end

endmodule

>>> sv/rdte_fifo.sv
// rdte_fifo: small command queue between front and back
// depends on rdte_pkg
module rdte_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rdte_pkg::t_cmd i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output rdte_pkg::t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rdte_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        n_count = CNT_W'(r_count + CNT_W'(i_push) - CNT_W'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> sv/rdte_back.sv
// rdte_back: expands queued commands into tokens and holds the output register
// depends on rdte_pkg
module rdte_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  rdte_pkg::t_cmd              i_head,
    input  logic                        i_out_stall,
    output logic                        o_pop,
    output logic                        o_out_valid,
    output logic [1:0]                  o_token_kind,
    output logic [rdte_pkg::CHAN_W-1:0] o_run_minus_one,
    output logic [rdte_pkg::CHAN_W-1:0] o_blue_value,
    output logic [rdte_pkg::CHAN_W-1:0] o_green_value,
    output logic [rdte_pkg::CHAN_W-1:0] o_red_value,
    output logic                        o_last_of_item,
    output logic                        o_end_of_image
);

    logic                        r_valid, n_valid;
    logic                        r_phase, n_phase;
    rdte_pkg::t_kind             r_kind, n_kind;
    logic [rdte_pkg::CHAN_W-1:0] r_run, n_run, r_b, n_b, r_g, n_g, r_r, n_r;
    logic                        r_last, n_last, r_eoi, n_eoi;
    logic                        w_load, w_rep_now;

    assign o_out_valid     = r_valid;
    assign o_token_kind    = r_kind;
    assign o_run_minus_one = r_run;
    assign o_blue_value    = r_b;
    assign o_green_value   = r_g;
    assign o_red_value     = r_r;
    assign o_last_of_item  = r_last;
    assign o_end_of_image  = r_eoi;

    always_comb begin
        w_load    = i_head_valid && (!r_valid || !i_out_stall);
        w_rep_now = i_head.rep_valid && !r_phase;
        o_pop     = w_load && (!w_rep_now || !i_head.main_valid);

        n_valid = r_valid && i_out_stall;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_run   = r_run;
        n_b     = r_b;
        n_g     = r_g;
        n_r     = r_r;
        n_last  = r_last;
        n_eoi   = r_eoi;
        if (w_load) begin
            n_valid = 1'b1;
            if (w_rep_now) begin
                n_kind  = rdte_pkg::KIND_REPEAT;
                n_run   = i_head.rep_run;
                n_b     = rdte_pkg::ZERO_CHAN;
                n_g     = rdte_pkg::ZERO_CHAN;
                n_r     = rdte_pkg::ZERO_CHAN;
                n_last  = !i_head.main_valid;
                n_eoi   = i_head.eoi && !i_head.main_valid;
                n_phase = i_head.main_valid;
            end else begin
                n_kind  = i_head.kind;
                n_run   = rdte_pkg::ZERO_CHAN;
                n_b     = i_head.blue;
                n_g     = i_head.green;
                n_r     = i_head.red;
                n_last  = 1'b1;
                n_eoi   = i_head.eoi;
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_run  <= n_run;
        r_b    <= n_b;
        r_g    <= n_g;
        r_r    <= n_r;
        r_last <= n_last;
        r_eoi  <= n_eoi;
    end

endmodule

>>> sv/rdte_checker.sv
// rdte_checker: port-level assertions for the token encoder, bound to the top level
// depends on rdte_pkg and rle_delta_rgb555_token_encoder
module rdte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_token_kind,
    input logic [4:0] o_run_minus_one,
    input logic [4:0] o_blue_value,
    input logic [4:0] o_green_value,
    input logic [4:0] o_red_value,
    input logic       o_last_of_item,
    input logic       o_end_of_image
);

    // stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_token_kind)
        && $stable(o_run_minus_one) && $stable(o_blue_value) && $stable(o_green_value)
        && $stable(o_red_value) && $stable(o_last_of_item) && $stable(o_end_of_image))
        else $error("stalled token changed");

    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_image |-> o_last_of_item)
        else $error("end of image without last of item");

    a_repeat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_kind == rdte_pkg::KIND_REPEAT) |->
        (o_blue_value == '0) && (o_green_value == '0) && (o_red_value == '0))
        else $error("repeat token with color data");

    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_token_kind == rdte_pkg::KIND_ASCEND)
        || (o_token_kind == rdte_pkg::KIND_DESCEND)) |->
        (o_run_minus_one == '0) && (o_blue_value[4:3] == 2'b00)
        && (o_green_value[4:3] == 2'b00) && (o_red_value[4:3] == 2'b00))
        else $error("delta token out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("token valid after reset");

endmodule

bind rle_delta_rgb555_token_encoder rdte_checker u_rdte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_token_kind    (o_token_kind),
    .o_run_minus_one (o_run_minus_one),
    .o_blue_value    (o_blue_value),
    .o_green_value   (o_green_value),
    .o_red_value     (o_red_value),
    .o_last_of_item  (o_last_of_item),
    .o_end_of_image  (o_end_of_image)
);

>>> tb/sv/tb_rle_delta_rgb555_token_encoder.sv
`timescale 1ns / 1ps
// tb_rle_delta_rgb555_token_encoder: self-checking bench for the rgb555 run/delta token encoder
// drives pixel transactions, predicts the token stream and checks it field by field
// depends on rdte_pkg and rle_delta_rgb555_token_encoder
module tb_rle_delta_rgb555_token_encoder;

    localparam int RANDOM_PIXELS = 1750;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 16;
    localparam logic [4:0] DELTA_LIMIT = 5'd7;

    typedef struct packed {
        rdte_pkg::t_kind kind;
        logic [4:0]      run_m1;
        logic [4:0]      blue;
        logic [4:0]      green;
        logic [4:0]      red;
        logic            last_tok;
        logic            eoi;
    } t_enc_token;

    typedef struct packed {
        logic [15:0] px;
        logic        fin;
    } t_pixel_txn;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_pixel = 16'd0;
    logic        i_final_pixel = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_token_kind;
    logic [4:0]  o_run_minus_one;
    logic [4:0]  o_blue_value;
    logic [4:0]  o_green_value;
    logic [4:0]  o_red_value;
    logic        o_last_of_item;
    logic        o_end_of_image;

    rle_delta_rgb555_token_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel         (i_pixel),
        .i_final_pixel   (i_final_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_kind    (o_token_kind),
        .o_run_minus_one (o_run_minus_one),
        .o_blue_value    (o_blue_value),
        .o_green_value   (o_green_value),
        .o_red_value     (o_red_value),
        .o_last_of_item  (o_last_of_item),
        .o_end_of_image  (o_end_of_image)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_pixel_txn pending_pixels[$];
    t_enc_token expected_tokens[$];

    // predictor state: last color and pending run
    logic [4:0] last_blue  = 5'd0;
    logic [4:0] last_green = 5'd0;
    logic [4:0] last_red   = 5'd0;
    logic [5:0] run_len    = 6'd0;

    int mismatches     = 0;
    int pixels_sent    = 0;
    int images_done    = 0;
    int tokens_checked = 0;
    int full_runs      = 0;
    int kind_seen[4]   = '{0, 0, 0, 0};
    int in_pace        = 1;
    int out_pace       = 1;
    int gap_left       = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;

    // random generator state
    logic [15:0] gen_prev   = 16'd0;
    int          img_left   = 0;
    int          rand_count = 0;

    function automatic t_enc_token make_token(rdte_pkg::t_kind kind, logic [4:0] run_m1,
                                              logic [4:0] b, logic [4:0] g, logic [4:0] r);
        t_enc_token t;
        t.kind     = kind;
        t.run_m1   = run_m1;
        t.blue     = b;
        t.green    = g;
        t.red      = r;
        t.last_tok = 1'b0;
        t.eoi      = 1'b0;
        return t;
    endfunction

    task automatic encode_pixel(input logic [15:0] px, input logic fin);
        t_enc_token toks[$];
        logic [4:0] b, g, r, ub, ug, ur, db, dg, dr;
        b = px[4:0];
        g = px[10:6];
        r = px[15:11];
        if (b == last_blue && g == last_green && r == last_red
            && run_len < rdte_pkg::RUN_MAX) begin
            run_len = run_len + 6'd1;
        end else begin
            if (run_len != 6'd0) begin
                toks.push_back(make_token(rdte_pkg::KIND_REPEAT, 5'(run_len - 6'd1),
                                          rdte_pkg::ZERO_CHAN, rdte_pkg::ZERO_CHAN,
                                          rdte_pkg::ZERO_CHAN));
                run_len = 6'd0;
            end
            ub = b - last_blue;
            ug = g - last_green;
            ur = r - last_red;
            db = last_blue - b;
            dg = last_green - g;
            dr = last_red - r;
            if (ub <= DELTA_LIMIT && ug <= DELTA_LIMIT && ur <= DELTA_LIMIT) begin
                toks.push_back(make_token(rdte_pkg::KIND_ASCEND, 5'd0, ub, ug, ur));
            end else if (db <= DELTA_LIMIT && dg <= DELTA_LIMIT && dr <= DELTA_LIMIT) begin
                toks.push_back(make_token(rdte_pkg::KIND_DESCEND, 5'd0, db, dg, dr));
            end else begin
                toks.push_back(make_token(rdte_pkg::KIND_RAW, 5'd0, b, g, r));
            end
            last_blue  = b;
            last_green = g;
            last_red   = r;
        end
        if (fin) begin
            if (run_len != 6'd0) begin
                toks.push_back(make_token(rdte_pkg::KIND_REPEAT, 5'(run_len - 6'd1),
                                          rdte_pkg::ZERO_CHAN, rdte_pkg::ZERO_CHAN,
                                          rdte_pkg::ZERO_CHAN));
            end
            toks[toks.size() - 1].eoi = 1'b1;
            last_blue  = 5'd0;
            last_green = 5'd0;
            last_red   = 5'd0;
            run_len    = 6'd0;
        end
        if (toks.size() != 0) begin
            toks[toks.size() - 1].last_tok = 1'b1;
        end
        foreach (toks[k]) begin
            expected_tokens.push_back(toks[k]);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on token %0d: %s", $realtime, tokens_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    function automatic int draw_wait(int pace);
        case (pace)
            0: return 0;
            1: return $urandom_range(0, 14);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [15:0] pack_rgb(logic [4:0] r, logic [4:0] g, logic [4:0] b,
                                             logic spare);
        return {r, g, spare, b};
    endfunction

    task automatic push_pixel(input logic [15:0] px, input logic fin);
        t_pixel_txn item;
        item.px  = px;
        item.fin = fin;
        pending_pixels.push_back(item);
    endtask

    // random pixel inside a random-length image; black again after the final one
    task automatic push_random(input logic [15:0] px);
        if (img_left == 0) begin
            img_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                   : $urandom_range(5, 120);
        end
        img_left--;
        push_pixel(px, img_left == 0);
        gen_prev = (img_left == 0) ? 16'd0 : px;
        rand_count++;
    endtask

    task automatic fill_random();
        int mode, len;
        logic [4:0] b, g, r;
        while (rand_count < RANDOM_PIXELS) begin
            mode = $urandom_range(0, 9);
            b = gen_prev[4:0];
            g = gen_prev[10:6];
            r = gen_prev[15:11];
            if (mode <= 2) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 70)
                                                  : $urandom_range(1, 8);
                repeat (len) begin
                    push_random(pack_rgb(r, g, b, 1'($urandom_range(0, 1))));
                end
            end else if (mode <= 4) begin
                push_random(pack_rgb(r + 5'($urandom_range(0, 7)), g + 5'($urandom_range(0, 7)),
                                     b + 5'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
            end else if (mode <= 6) begin
                push_random(pack_rgb(r - 5'($urandom_range(0, 7)), g - 5'($urandom_range(0, 7)),
                                     b - 5'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
            end else if (mode == 7) begin
                // one channel just past the delta window
                case ($urandom_range(0, 2))
                    0: b = ($urandom_range(0, 1) != 0) ? b + 5'd8 : b - 5'd8;
                    1: g = ($urandom_range(0, 1) != 0) ? g + 5'd8 : g - 5'd8;
                    default: r = ($urandom_range(0, 1) != 0) ? r + 5'd8 : r - 5'd8;
                endcase
                push_random(pack_rgb(r, g, b, 1'($urandom_range(0, 1))));
            end else begin
                push_random(16'($urandom_range(0, 65535)));
            end
        end
        if (img_left != 0) begin
            // close the open image
            img_left = 1;
            push_random(16'($urandom_range(0, 65535)));
        end
    endtask

    // driver: one pixel transaction at a time, random gap after each
    always @(posedge i_clk) begin
        logic accepted;
        t_pixel_txn item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            accepted = i_in_valid && !o_in_stall;
            if (accepted) begin
                encode_pixel(i_pixel, i_final_pixel);
                pixels_sent++;
                if (i_final_pixel) images_done++;
                if ($urandom_range(0, 99) == 0) in_pace = $urandom_range(0, 2);
                gap_left = draw_wait(in_pace);
            end
            if (accepted || !i_in_valid) begin
                if (gap_left == 0 && pending_pixels.size() != 0) begin
                    item = pending_pixels.pop_front();
                    i_pixel       <= item.px;
                    i_final_pixel <= item.fin;
                    i_in_valid    <= 1'b1;
                end else begin
                    if (gap_left != 0) gap_left--;
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each token transaction and stalls the output at random
    always @(posedge i_clk) begin
        t_enc_token want;
        int w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d", o_token_kind));
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", int'(want.kind), o_token_kind);
                check_field("run_minus_one", want.run_m1, o_run_minus_one);
                check_field("blue_value", want.blue, o_blue_value);
                check_field("green_value", want.green, o_green_value);
                check_field("red_value", want.red, o_red_value);
                check_field("last_of_item", want.last_tok, o_last_of_item);
                check_field("end_of_image", want.eoi, o_end_of_image);
            end
            kind_seen[o_token_kind]++;
            if (o_token_kind == rdte_pkg::KIND_REPEAT && o_run_minus_one == 5'd31) full_runs++;
            tokens_checked++;
            if ($urandom_range(0, 99) == 0) out_pace = $urandom_range(0, 2);
            w = draw_wait(out_pace);
            stall_left = w;
            if (w != 0) i_out_stall <= 1'b1;
        end else if (stall_left > 1) begin
            stall_left--;
        end else if (stall_left == 1) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        // directed: run from reset, bit 5 ignored, flush on final
        push_pixel(pack_rgb(5'd0, 5'd0, 5'd0, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd0, 5'd0, 5'd0, 1'b1), 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'h0000, 1'b1);
        // ascend, descend, raw, run flush, wrapping deltas
        push_pixel(pack_rgb(5'd7, 5'd7, 5'd7, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd7, 5'd0, 5'd7, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd7, 5'd8, 5'd7, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd7, 5'd8, 5'd7, 1'b1), 1'b0);
        push_pixel(pack_rgb(5'd7, 5'd8, 5'd7, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd30, 5'd8, 5'd2, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd2, 5'd12, 5'd5, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd29, 5'd8, 5'd31, 1'b1), 1'b0);
        push_pixel(pack_rgb(5'd31, 5'd31, 5'd31, 1'b0), 1'b0);
        push_pixel(pack_rgb(5'd0, 5'd0, 5'd0, 1'b0), 1'b1);
        // full run of black, then the tie between ascend and descend
        for (int k = 0; k < 35; k++) begin
            push_pixel(pack_rgb(5'd0, 5'd0, 5'd0, 1'(k % 2)), k == 34);
        end
        fill_random();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || i_in_valid || expected_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d pixels in %0d images, %0d tokens checked, %0d full runs",
                 pixels_sent, images_done, tokens_checked, full_runs);
        $display("token mix: repeat %0d, raw %0d, ascend %0d, descend %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
